FILE: sv/assert_macros.svh
// Assertion macros used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/gsem_pkg.sv
// Types and constants of the single-edge map block.
`timescale 1ns / 1ps
package gsem_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned QUOT_W = DATA_W + 1;
  localparam int unsigned STEP_W = 5;

  localparam logic [STEP_W-1:0] STEPS_MOD  = 5'd16;
  localparam logic [STEP_W-1:0] STEPS_FRAC = 5'd17;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_MOD,
    ST_FETCH,
    ST_START,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              start;
    logic              mode_mod;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: sv/gsem_in_if.sv
// Input channel: opcode, pixel address and gradient pair.
`timescale 1ns / 1ps
interface gsem_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [15:0]        pixel_index;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;

  modport source (output valid, opcode, pixel_index, grad_x, grad_y, input ready);
  modport sink   (input valid, opcode, pixel_index, grad_x, grad_y, output ready);
endinterface

FILE: sv/gsem_out_if.sv
// Output channel: readout address and normalized edge level.
`timescale 1ns / 1ps
interface gsem_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_index;
  logic [15:0] edge_level;

  modport source (output valid, read_index, edge_level, input ready);
  modport sink   (input valid, read_index, edge_level, output ready);
endinterface

FILE: sv/gsem_div.sv
// Shared radix-2 restoring divider: Q1.16 fraction or 16-bit remainder.
`timescale 1ns / 1ps
module gsem_div import gsem_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, done_q, first_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DATA_W-1:0] r_q, sh_q, den_q;
  logic [QUOT_W-1:0] q_q;

  logic [DATA_W:0]   trial, diff;
  logic              ge;
  logic [DATA_W-1:0] r_d;

  always_comb begin
    trial = first_q ? {1'b0, r_q} : {r_q, sh_q[DATA_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    r_d   = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        first_q <= !req_i.mode_mod;
        cnt_q   <= req_i.mode_mod ? STEPS_MOD : STEPS_FRAC;
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q   <= req_i.mode_mod ? '0 : req_i.num;
      sh_q  <= req_i.mode_mod ? req_i.num : '0;
      den_q <= req_i.den;
      q_q   <= '0;
    end else if (busy_q) begin
      r_q  <= r_d;
      sh_q <= {sh_q[DATA_W-2:0], 1'b0};
      q_q  <= {q_q[QUOT_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q;

endmodule

FILE: sv/gradient_single_edge_map_core.sv
// Top level: single-edge map with per-pixel maximum and global normalization.
//
//   port   dir  beat contents
//   req_i  in   opcode, pixel_index, grad_x, grad_y
//   rsp_o  out  read_index, edge_level (readouts only)
//
// Load and readout pass through the 17 steps of the shared divider before the next
// beat is taken (a load whose larger gradient magnitude is zero skips them); when
// MAP_DEPTH is not a power of two and below 65536 the address reduction runs 16 more
// divider steps first. A clear zeroes the map, one map entry per cycle.
// After reset the same sweep runs before the first beat is taken.
// A finished readout waits in the output register; a further readout holds in
// its last step while that register is still full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gradient_single_edge_map_core import gsem_pkg::*; #(
  parameter int unsigned MAP_DEPTH  = 65536,
  parameter int unsigned GRAD_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gsem_in_if.sink     req_i,
  gsem_out_if.source  rsp_o
);

  localparam int unsigned ADDR_W = $clog2(MAP_DEPTH);
  localparam int unsigned GW_EFF = (GRAD_WIDTH < 16) ? GRAD_WIDTH : 16;
  localparam int unsigned EXT_W  = DATA_W + 1;
  localparam bit NEED_MOD = (MAP_DEPTH < 65536) && ((MAP_DEPTH & (MAP_DEPTH - 1)) != 0);
  localparam logic [DATA_W-1:0] MOD_DEN   = NEED_MOD ? DATA_W'(MAP_DEPTH) : DATA_W'(1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] clr_cnt_q;
  logic [DATA_W-1:0] peak_q;
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [DATA_W-1:0] out_level_q;

  op_e               op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [15:0]       gx_q, gy_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] hi_q, lo_q;
  logic [DATA_W-1:0] mem_rd_q;

  logic [DATA_W-1:0] mem [MAP_DEPTH];

  logic              accept, out_free, clr_last;
  logic [31:0]       idx_ext, rem_ext;
  logic signed [EXT_W-1:0] gx_s, gy_s;
  logic [DATA_W-1:0] ax, ay;
  logic [DATA_W-1:0] frac;

  logic              mem_we, mem_re, out_push, peak_set;
  logic [ADDR_W-1:0] mem_wa;
  logic [DATA_W-1:0] mem_wd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  gsem_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign req_i.ready      = (state_q == ST_IDLE);
  assign accept           = req_i.valid && req_i.ready;
  assign out_free         = !out_valid_q || rsp_o.ready;
  assign clr_last         = (clr_cnt_q == LAST_ADDR);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_index = out_idx_q;
  assign rsp_o.edge_level = out_level_q;

  always_comb begin
    idx_ext = {16'b0, req_i.pixel_index};
    rem_ext = {16'b0, div_rsp.rem};
    gx_s    = EXT_W'(signed'(gx_q[GW_EFF-1:0]));
    gy_s    = EXT_W'(signed'(gy_q[GW_EFF-1:0]));
    ax      = gx_s[EXT_W-1] ? DATA_W'(-gx_s) : DATA_W'(gx_s);
    ay      = gy_s[EXT_W-1] ? DATA_W'(-gy_s) : DATA_W'(gy_s);
    frac    = div_rsp.quot[QUOT_W-1] ? '1 : div_rsp.quot[DATA_W-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(req_i.opcode)) inside
            OP_LOAD, OP_READ: state_d = ST_PREP;
            OP_CLEAR:         state_d = ST_CLEAR;
            default:          state_d = ST_IDLE;
          endcase
        end
      end
      ST_PREP:   state_d = NEED_MOD ? ST_MOD : ST_FETCH;
      ST_MOD:    if (div_rsp.done) state_d = ST_FETCH;
      ST_FETCH:  state_d = ST_START;
      ST_START:  state_d = (op_q == OP_LOAD && hi_q == '0) ? ST_IDLE : ST_DIV;
      ST_DIV:    if (div_rsp.done) state_d = ST_FINISH;
      ST_FINISH: if (op_q == OP_LOAD || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wa   = addr_q;
    mem_wd   = frac;
    out_push = 1'b0;
    peak_set = 1'b0;
    div_req  = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_q;
        mem_wd = '0;
      end
      ST_PREP: begin
        div_req.start    = NEED_MOD;
        div_req.mode_mod = 1'b1;
        div_req.num      = idx_q;
        div_req.den      = MOD_DEN;
      end
      ST_FETCH: mem_re = 1'b1;
      ST_START: begin
        if (op_q == OP_LOAD) begin
          div_req.start = (hi_q != '0);
          div_req.num   = hi_q - lo_q;
          div_req.den   = hi_q;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = mem_rd_q;
          div_req.den   = peak_q;
        end
      end
      ST_FINISH: begin
        if (op_q == OP_LOAD) begin
          mem_we   = frac > mem_rd_q;
          peak_set = frac > peak_q;
        end else begin
          out_push = out_free;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
        peak_q    <= '0;
      end else if (peak_set) begin
        peak_q <= frac;
      end
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(req_i.opcode);
      idx_q  <= req_i.pixel_index;
      gx_q   <= req_i.grad_x;
      gy_q   <= req_i.grad_y;
      addr_q <= idx_ext[ADDR_W-1:0];
    end
    if (state_q == ST_MOD && div_rsp.done) begin
      addr_q <= rem_ext[ADDR_W-1:0];
    end
    if (state_q == ST_PREP) begin
      hi_q <= (ax > ay) ? ax : ay;
      lo_q <= (ax > ay) ? ay : ax;
    end
    if (out_push) begin
      out_idx_q   <= idx_q;
      out_level_q <= (peak_q == '0) ? '0 : frac;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rd_q <= mem[addr_q];
    end
  end

  `ASSERT_IMP(a_ready_div_idle, req_i.ready, !div_rsp.busy)
  `ASSERT_IMP(a_done_in_wait, div_rsp.done, (state_q == ST_MOD) || (state_q == ST_DIV))
  `ASSERT_NXT(a_peak_rises, state_q != ST_CLEAR, peak_q >= $past(peak_q))
  `ASSERT_IMP(a_beat_from_read, $rose(out_valid_q), $past(op_q) == OP_READ)

endmodule
